// ----- hw/rtl/mkrms_pkg.sv -----
// Shared types for the multi-key record merge sorter.
// Holds the controller state, datapath operation codes and the record layout.
`default_nettype none
package mkrms_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_PASS,
    ST_RUN,
    ST_RD_IDX,
    ST_RD_REC,
    ST_MERGE,
    ST_RUN_NEXT,
    ST_PASS_END,
    ST_EMIT_IDX,
    ST_EMIT_REC,
    ST_EMIT_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_STEP,
    OP_RUN_BEGIN,
    OP_RD_IDX,
    OP_RD_REC,
    OP_MERGE,
    OP_RUN_NEXT,
    OP_PASS_END,
    OP_EMIT_BEGIN,
    OP_EMIT_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic last_k;     // k is the final position of the set
    logic pass_more;  // another merge pass is needed
    logic run_done;   // current run fully written
    logic runs_more;  // another run follows in this pass
  } sts_t;

  // Field order gives the sort priority when compared as one vector.
  typedef struct packed {
    logic [29:0] key_date;
    logic [63:0] name_first;
    logic [63:0] name_middle;
    logic [31:0] name_final;
    logic [37:0] seat_weight;
  } rec_t;

endpackage
`default_nettype wire

// ----- hw/rtl/multi_key_record_merge_sorter.sv -----
// Top level of the multi-key record merge sorter: APB register and wiring.
// Depends on mkrms_pkg, mkrms_ctrl and mkrms_dp.
`default_nettype none
// Records are loaded one per request while busy is low. The request with
// last_i high closes the set and starts a bottom-up stable merge sort
// over an index array. Every stored record then comes out in order, with
// a one-cycle strobe on result_valid_o after an index read and a record read;
// the receiver cannot stall. The merge unit has one compare and reads the
// order bank and the record store in turn, so each merge step passes through
// an index read state, a record read state and a merge state. A set passes
// through loading, seeding of the index bank, the merge passes and emission.
// Records past MAX_RECORDS are dropped and overflow_o is high on all results
// of that set. Register 0 (address 0, bit 0) selects descending order; ties
// keep arrival order either way. Name bytes of the middle and final fields
// beyond NAME_BYTES read as zero.
module multi_key_record_merge_sorter #(
  parameter int MAX_RECORDS = 64,
  parameter int NAME_BYTES  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  flight_no_i,
  input  logic [10:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [63:0] name_bytes_first_i,
  input  logic [63:0] name_bytes_middle_i,
  input  logic [31:0] name_bytes_final_i,
  input  logic [23:0] seat_code_i,
  input  logic [13:0] weight_centi_i,
  input  logic        last_i,
  output logic        result_valid_o,
  output logic [9:0]  out_flight_no_o,
  output logic [10:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [63:0] out_name_first_o,
  output logic [63:0] out_name_middle_o,
  output logic [31:0] out_name_final_o,
  output logic [23:0] out_seat_o,
  output logic [13:0] out_weight_o,
  output logic        out_last_o,
  output logic        overflow_o
);
  import mkrms_pkg::*;

  logic desc_q;
  cmd_t cmd;
  sts_t sts;
  rec_t rec_in, rec_out;

  // Descending flag: word address 0 only.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      desc_q <= pwdata[0];
    end
  end
  assign prdata = paddr[2] ? 32'd0 : {31'd0, desc_q};

  assign rec_in.key_date    = {flight_no_i, year_i, month_i, day_i};
  assign rec_in.name_first  = name_bytes_first_i;
  assign rec_in.name_middle = name_bytes_middle_i;
  assign rec_in.name_final  = name_bytes_final_i;
  assign rec_in.seat_weight = {seat_code_i, weight_centi_i};

  mkrms_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .last_i  (last_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .emit_o  (result_valid_o)
  );

  mkrms_dp #(
    .MAX_RECORDS (MAX_RECORDS),
    .NAME_BYTES  (NAME_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .desc_i     (desc_q),
    .rec_i      (rec_in),
    .rec_o      (rec_out),
    .out_last_o (out_last_o),
    .overflow_o (overflow_o)
  );

  assign out_flight_no_o   = rec_out.key_date[29:20];
  assign out_year_o        = rec_out.key_date[19:9];
  assign out_month_o       = rec_out.key_date[8:5];
  assign out_day_o         = rec_out.key_date[4:0];
  assign out_name_first_o  = rec_out.name_first;
  assign out_name_middle_o = rec_out.name_middle;
  assign out_name_final_o  = rec_out.name_final;
  assign out_seat_o        = rec_out.seat_weight[37:14];
  assign out_weight_o      = rec_out.seat_weight[13:0];

endmodule
`default_nettype wire

// ----- hw/rtl/mkrms_ctrl.sv -----
// Sequencing state machine of the merge sorter.
// Depends on mkrms_pkg; drives datapath operations from its status.
`default_nettype none
module mkrms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            last_i,
  input  mkrms_pkg::sts_t sts_i,
  output mkrms_pkg::cmd_t cmd_o,
  output logic            busy_o,
  output logic            emit_o
);
  import mkrms_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start_i && last_i) state_d = ST_INIT;
      ST_INIT:     if (sts_i.last_k) state_d = ST_PASS;
      ST_PASS:     state_d = sts_i.pass_more ? ST_RUN : ST_EMIT_IDX;
      ST_RUN:      state_d = ST_RD_IDX;
      ST_RD_IDX:   state_d = ST_RD_REC;
      ST_RD_REC:   state_d = ST_MERGE;
      ST_MERGE:    state_d = sts_i.run_done ? ST_RUN_NEXT : ST_RD_IDX;
      ST_RUN_NEXT: state_d = sts_i.runs_more ? ST_RUN : ST_PASS_END;
      ST_PASS_END: state_d = ST_PASS;
      ST_EMIT_IDX: state_d = ST_EMIT_REC;
      ST_EMIT_REC: state_d = ST_EMIT_OUT;
      ST_EMIT_OUT: state_d = sts_i.last_k ? ST_IDLE : ST_EMIT_IDX;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      ST_IDLE:     if (start_i) cmd_o.op = OP_LOAD;
      ST_INIT:     cmd_o.op = OP_INIT_STEP;
      ST_PASS:     cmd_o.op = sts_i.pass_more ? OP_NONE : OP_EMIT_BEGIN;
      ST_RUN:      cmd_o.op = OP_RUN_BEGIN;
      ST_RD_IDX:   cmd_o.op = OP_RD_IDX;
      ST_RD_REC:   cmd_o.op = OP_RD_REC;
      ST_MERGE:    cmd_o.op = OP_MERGE;
      ST_RUN_NEXT: cmd_o.op = OP_RUN_NEXT;
      ST_PASS_END: cmd_o.op = OP_PASS_END;
      ST_EMIT_IDX: cmd_o.op = OP_RD_IDX;
      ST_EMIT_REC: cmd_o.op = OP_RD_REC;
      ST_EMIT_OUT: cmd_o.op = OP_EMIT_OUT;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign emit_o = (state_q == ST_EMIT_OUT);

endmodule
`default_nettype wire

// ----- hw/rtl/mkrms_dp.sv -----
// Datapath of the merge sorter: record store, two order banks, run counters.
// Depends on mkrms_pkg; commanded by mkrms_ctrl.
`default_nettype none
module mkrms_dp #(
  parameter int MAX_RECORDS = 64,
  parameter int NAME_BYTES  = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mkrms_pkg::cmd_t cmd_i,
  output mkrms_pkg::sts_t sts_o,
  input  logic            desc_i,
  input  mkrms_pkg::rec_t rec_i,
  output mkrms_pkg::rec_t rec_o,
  output logic            out_last_o,
  output logic            overflow_o
);
  import mkrms_pkg::*;

  localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int W1 = CW + 1;
  localparam int KM = (NAME_BYTES - 8 > 8) ? 8 : ((NAME_BYTES < 8) ? 0 : NAME_BYTES - 8);
  localparam int KF = (NAME_BYTES - 16 > 4) ? 4 : ((NAME_BYTES < 16) ? 0 : NAME_BYTES - 16);
  localparam logic [63:0] MASK_MID = ~64'd0 << (8 * (8 - KM));
  localparam logic [31:0] MASK_FIN = ~32'd0 << (8 * (4 - KF));

  rec_t          rec_mem [MAX_RECORDS];
  logic [IW-1:0] ord_a   [MAX_RECORDS];
  logic [IW-1:0] ord_b   [MAX_RECORDS];

  logic [CW-1:0] cnt_q;
  logic          ovf_q, bank_q;
  logic [W1-1:0] width_q, lo_q, mid_q, hi_q, p_q, q_q, k_q;
  logic [IW-1:0] idxp_q, idxq_q;
  rec_t          recp_q, recq_q;

  logic [W1-1:0] cnt_x, two_w, lo_next, mid_c, hi_c;
  logic          take_p, le;
  rec_t          rec_w;

  assign cnt_x   = W1'(cnt_q);
  assign two_w   = width_q << 1;
  assign lo_next = lo_q + two_w;
  assign mid_c   = (lo_q + width_q < cnt_x) ? lo_q + width_q : cnt_x;
  assign hi_c    = (lo_next < cnt_x) ? lo_next : cnt_x;

  assign le     = desc_i ? (recp_q >= recq_q) : (recp_q <= recq_q);
  assign take_p = (p_q < mid_q) && ((q_q >= hi_q) || le);

  always_comb begin
    rec_w             = rec_i;
    rec_w.name_middle = rec_i.name_middle & MASK_MID;
    rec_w.name_final  = rec_i.name_final & MASK_FIN;
  end

  assign sts_o.last_k    = (k_q + W1'(1) == cnt_x);
  assign sts_o.pass_more = (width_q < cnt_x);
  assign sts_o.run_done  = (k_q + W1'(1) == hi_q);
  assign sts_o.runs_more = (lo_next < cnt_x);

  assign rec_o      = recp_q;
  assign out_last_o = sts_o.last_k;
  assign overflow_o = ovf_q;

  // Memories: no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && cnt_q < CW'(MAX_RECORDS)) begin
      rec_mem[cnt_q[IW-1:0]] <= rec_w;
    end
    if (cmd_i.op == OP_INIT_STEP) begin
      ord_a[k_q[IW-1:0]] <= k_q[IW-1:0];
    end
    if (cmd_i.op == OP_MERGE) begin
      if (bank_q) begin
        ord_a[k_q[IW-1:0]] <= take_p ? idxp_q : idxq_q;
      end else begin
        ord_b[k_q[IW-1:0]] <= take_p ? idxp_q : idxq_q;
      end
    end
    if (cmd_i.op == OP_RD_IDX) begin
      idxp_q <= bank_q ? ord_b[p_q[IW-1:0]] : ord_a[p_q[IW-1:0]];
      idxq_q <= bank_q ? ord_b[q_q[IW-1:0]] : ord_a[q_q[IW-1:0]];
    end
    if (cmd_i.op == OP_RD_REC) begin
      recp_q <= rec_mem[idxp_q];
      recq_q <= rec_mem[idxq_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
      width_q <= W1'(1);
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      p_q     <= '0;
      q_q     <= '0;
      k_q     <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          if (cnt_q < CW'(MAX_RECORDS)) cnt_q <= cnt_q + CW'(1);
          else ovf_q <= 1'b1;
          k_q     <= '0;
          lo_q    <= '0;
          width_q <= W1'(1);
          bank_q  <= 1'b0;
        end
        OP_INIT_STEP: k_q <= k_q + W1'(1);
        OP_RUN_BEGIN: begin
          mid_q <= mid_c;
          hi_q  <= hi_c;
          p_q   <= lo_q;
          q_q   <= mid_c;
          k_q   <= lo_q;
        end
        OP_MERGE: begin
          k_q <= k_q + W1'(1);
          if (take_p) p_q <= p_q + W1'(1);
          else q_q <= q_q + W1'(1);
        end
        OP_RUN_NEXT: lo_q <= lo_next;
        OP_PASS_END: begin
          width_q <= two_w;
          lo_q    <= '0;
          bank_q  <= ~bank_q;
        end
        OP_EMIT_BEGIN: begin
          k_q <= '0;
          p_q <= '0;
        end
        OP_EMIT_OUT: begin
          k_q <= k_q + W1'(1);
          p_q <= p_q + W1'(1);
          if (sts_o.last_k) begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        OP_NONE, OP_RD_IDX, OP_RD_REC: ;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mkrms_checker.sv -----
// Port-level checks for the merge sorter, bound to the top level.
// Sees the top level's ports only.
`default_nettype none
module mkrms_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_i,
  input logic result_valid_o,
  input logic out_last_o
);

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result while not busy");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && out_last_o |=> !result_valid_o && !busy)
    else $error("activity after final result");

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_i |=> busy) else $error("set close did not start sort");

  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(result_valid_o && out_last_o))
    else $error("busy dropped without final result");

endmodule

bind multi_key_record_merge_sorter mkrms_checker u_mkrms_checker (.*);
`default_nettype wire
